/* rtl/rdz_pkg.sv */
`default_nettype none

package rdz_pkg;

    localparam int SQRT_STEPS = 16;

    localparam logic [14:0] STICK_FULL   = 15'd32767;
    localparam logic [7:0]  TRIG_FULL    = 8'd255;
    localparam logic [14:0] STICK_DZ_RST = 15'd7849;
    localparam logic [7:0]  TRIG_DZ_RST  = 8'd30;

    typedef enum logic [7:0] {
        CFG_STICK_DZ = 8'd0,
        CFG_TRIG_DZ  = 8'd1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* rtl/rdz_div_pipe.sv */
`default_nettype none

// Restoring divider, one quotient bit per stage. Requires i_num >> QW < i_den.
module rdz_div_pipe #(
    parameter int QW = 16,
    parameter int DW = 16,
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [QW+DW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [PW-1:0]      i_pay,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);

    logic [DW-1:0] st_rem [0:QW];
    logic [QW-1:0] st_acc [0:QW];
    logic [DW-1:0] st_den [0:QW];
    logic [PW-1:0] st_pay [0:QW];
    logic          st_vld [0:QW];

    assign st_rem[0] = i_num[QW+DW-1:QW];
    assign st_acc[0] = i_num[QW-1:0];
    assign st_den[0] = i_den;
    assign st_pay[0] = i_pay;
    assign st_vld[0] = i_vld;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW:0]   w_trial;
        logic          w_ge;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_acc;
        logic [DW-1:0] r_den;
        logic [PW-1:0] r_pay;
        logic          r_vld;

        assign w_trial = {st_rem[i], st_acc[i][QW-1]};
        assign w_ge    = w_trial >= {1'b0, st_den[i]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= st_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? DW'(w_trial - {1'b0, st_den[i]}) : w_trial[DW-1:0];
                r_acc <= {st_acc[i][QW-2:0], w_ge};
                r_den <= st_den[i];
                r_pay <= st_pay[i];
            end
        end

        assign st_rem[i+1] = r_rem;
        assign st_acc[i+1] = r_acc;
        assign st_den[i+1] = r_den;
        assign st_pay[i+1] = r_pay;
        assign st_vld[i+1] = r_vld;
    end

    assign o_vld = st_vld[QW];
    assign o_quo = st_acc[QW];
    assign o_pay = st_pay[QW];

endmodule

`default_nettype wire

/* rtl/rdz_sqrt_pipe.sv */
`default_nettype none

// Integer square root of a 32-bit value, one root bit per stage.
module rdz_sqrt_pipe
    import rdz_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [31:0]   i_rad,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [15:0]   o_root,
    output logic [PW-1:0] o_pay
);

    logic [16:0]   st_rem  [0:SQRT_STEPS];
    logic [15:0]   st_root [0:SQRT_STEPS];
    logic [31:0]   st_sh   [0:SQRT_STEPS];
    logic [PW-1:0] st_pay  [0:SQRT_STEPS];
    logic          st_vld  [0:SQRT_STEPS];

    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_sh[0]   = i_rad;
    assign st_pay[0]  = i_pay;
    assign st_vld[0]  = i_vld;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
        logic [18:0]   w_acc;
        logic [18:0]   w_trial;
        logic          w_ge;
        logic [16:0]   r_rem;
        logic [15:0]   r_root;
        logic [31:0]   r_sh;
        logic [PW-1:0] r_pay;
        logic          r_vld;

        assign w_acc   = {st_rem[i], st_sh[i][31:30]};
        assign w_trial = {1'b0, st_root[i], 2'b01};
        assign w_ge    = w_acc >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= st_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? 17'(w_acc - w_trial) : w_acc[16:0];
                r_root <= {st_root[i][14:0], w_ge};
                r_sh   <= {st_sh[i][29:0], 2'b00};
                r_pay  <= st_pay[i];
            end
        end

        assign st_rem[i+1]  = r_rem;
        assign st_root[i+1] = r_root;
        assign st_sh[i+1]   = r_sh;
        assign st_pay[i+1]  = r_pay;
        assign st_vld[i+1]  = r_vld;
    end

    assign o_vld  = st_vld[SQRT_STEPS];
    assign o_root = st_root[SQRT_STEPS];
    assign o_pay  = st_pay[SQRT_STEPS];

endmodule

`default_nettype wire

/* rtl/radial_deadzone_stick_normalizer_unit.sv */
`default_nettype none

// Stick and trigger normalizer with a scaled radial dead zone. Each input
// transaction carries one stick sample (X, Y) and one trigger sample and yields
// one output transaction: the stick direction scaled by the remapped magnitude
// in Q1.15, and the trigger remapped above its dead zone in Q0.16. The pipeline
// takes one transaction per cycle unless the output stalls; its path includes
// the 16-stage square root, the OUT_FRAC_BITS-stage gain divider and the
// 16-stage axis dividers. The whole pipeline holds while the output register
// is full and not taken. The user must write dead zones through the config
// port only while the unit is idle; the unit itself does not enforce this.
module radial_deadzone_stick_normalizer_unit
    import rdz_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,    // stick_x, stick_y, trigger_raw
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // norm_x, norm_y, norm_trigger
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int GW  = F + 1;
    localparam int PXW = 16 + GW;
    localparam int AW  = PXW + 17;

    logic w_en;

    // config
    logic [14:0] r_stick_dz;
    logic [7:0]  r_trig_dz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_dz <= STICK_DZ_RST;
            r_trig_dz  <= TRIG_DZ_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STICK_DZ) r_stick_dz <= i_cfg_data[14:0];
            if (i_cfg_index == CFG_TRIG_DZ)  r_trig_dz  <= i_cfg_data[7:0];
        end
    end

    // stage A: squares and trigger numerator
    logic signed [15:0] w_x, w_y;
    logic [7:0]         w_t, w_td, w_tden;
    logic               w_tlive;
    logic signed [31:0] w_xx, w_yy;

    assign w_x     = i_s_tdata[15:0];
    assign w_y     = i_s_tdata[31:16];
    assign w_t     = i_s_tdata[39:32];
    assign w_xx    = w_x * w_x;
    assign w_yy    = w_y * w_y;
    assign w_tlive = w_t > r_trig_dz;
    assign w_td    = w_t - r_trig_dz;
    assign w_tden  = TRIG_FULL - r_trig_dz;

    logic        r_a_vld;
    logic [30:0] r_a_xx, r_a_yy;
    logic [29:0] r_a_dzsq;
    logic [15:0] r_a_x, r_a_y;
    logic [14:0] r_a_dz;
    logic [24:0] r_a_tnum;
    logic [8:0]  r_a_tden2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_xx   <= w_xx[30:0];
            r_a_yy   <= w_yy[30:0];
            r_a_dzsq <= r_stick_dz * r_stick_dz;
            r_a_x    <= w_x;
            r_a_y    <= w_y;
            r_a_dz   <= r_stick_dz;
            // 2 * d * 65535 + den, halved rounding folded into a divide by 2*den
            r_a_tnum <= w_tlive ? (25'(w_td) << 17) - (25'(w_td) << 1) + 25'(w_tden)
                                : '0;
            r_a_tden2 <= w_tlive ? {w_tden, 1'b0} : 9'd2;
        end
    end

    // stage B: magnitude squared and dead zone test
    logic        r_b_vld;
    logic [31:0] r_b_s;
    logic        r_b_live;
    logic [15:0] r_b_x, r_b_y;
    logic [14:0] r_b_dz;
    logic [24:0] r_b_tnum;
    logic [8:0]  r_b_tden2;
    logic [31:0] w_s;

    assign w_s = {1'b0, r_a_xx} + {1'b0, r_a_yy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_s     <= w_s;
            r_b_live  <= w_s > {2'b00, r_a_dzsq};
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
            r_b_dz    <= r_a_dz;
            r_b_tnum  <= r_a_tnum;
            r_b_tden2 <= r_a_tden2;
        end
    end

    // square root alongside the trigger divider
    logic        w_sq_vld;
    logic [15:0] w_r;
    logic [46:0] w_sq_pay;
    logic        w_tr_vld;
    logic [15:0] w_tq;
    logic        w_tr_live;

    rdz_sqrt_pipe #(.PW(47)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_b_vld),
        .i_rad   (r_b_s),
        .i_pay   ({r_b_x, r_b_y, r_b_dz}),
        .o_vld   (w_sq_vld),
        .o_root  (w_r),
        .o_pay   (w_sq_pay)
    );

    rdz_div_pipe #(.QW(16), .DW(9), .PW(1)) u_trig_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_b_vld),
        .i_num   (r_b_tnum),
        .i_den   (r_b_tden2),
        .i_pay   (r_b_live),
        .o_vld   (w_tr_vld),
        .o_quo   (w_tq),
        .o_pay   (w_tr_live)
    );

    // gain divider
    logic [15:0] w_c_x, w_c_y;
    logic [14:0] w_c_dz;
    logic        w_full;
    logic        w_gain_go;
    logic [14:0] w_gnum;
    logic [14:0] w_gden;

    assign w_c_x     = w_sq_pay[46:31];
    assign w_c_y     = w_sq_pay[30:15];
    assign w_c_dz    = w_sq_pay[14:0];
    assign w_full    = (w_r >= {1'b0, STICK_FULL}) || (w_c_dz == STICK_FULL);
    assign w_gain_go = w_tr_live && !w_full;
    assign w_gnum    = w_gain_go ? 15'(w_r - {1'b0, w_c_dz}) : '0;
    assign w_gden    = w_full ? 15'd1 : STICK_FULL - w_c_dz;

    logic          w_g_vld;
    logic [F-1:0]  w_gq;
    logic [65:0]   w_g_pay;

    rdz_div_pipe #(.QW(F), .DW(15), .PW(66)) u_gain_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld & w_tr_vld),
        .i_num   ({w_gnum, {F{1'b0}}}),
        .i_den   (w_gden),
        .i_pay   ({w_c_x, w_c_y, w_r, w_full, w_tr_live, w_tq}),
        .o_vld   (w_g_vld),
        .o_quo   (w_gq),
        .o_pay   (w_g_pay)
    );

    logic signed [15:0] w_g_x, w_g_y;
    logic [15:0]        w_g_r, w_g_tq;
    logic               w_g_full, w_g_live;
    logic [GW-1:0]      w_g;
    logic [15:0]        w_ax, w_ay;

    assign w_g_x    = w_g_pay[65:50];
    assign w_g_y    = w_g_pay[49:34];
    assign w_g_r    = w_g_pay[33:18];
    assign w_g_full = w_g_pay[17];
    assign w_g_live = w_g_pay[16];
    assign w_g_tq   = w_g_pay[15:0];
    assign w_g      = w_g_full ? (GW'(1) << F) : {1'b0, w_gq};
    assign w_ax     = w_g_x[15] ? 16'(-w_g_x) : w_g_x;
    assign w_ay     = w_g_y[15] ? 16'(-w_g_y) : w_g_y;

    // M1: |c| * gain
    logic           r_m1_vld;
    logic [PXW-1:0] r_m1_px, r_m1_py;
    logic           r_m1_sx, r_m1_sy, r_m1_live;
    logic [15:0]    r_m1_r, r_m1_tq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_en) begin
            r_m1_vld <= w_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_px   <= PXW'(w_ax) * PXW'(w_g);
            r_m1_py   <= PXW'(w_ay) * PXW'(w_g);
            r_m1_sx   <= w_g_x[15];
            r_m1_sy   <= w_g_y[15];
            r_m1_live <= w_g_live;
            r_m1_r    <= w_g_r;
            r_m1_tq   <= w_g_tq;
        end
    end

    // M2: times 32767, add half the divisor, drop the power-of-two part of it
    logic [AW-1:0] w_mx, w_my, w_rh, w_nx, w_ny;

    assign w_mx = (AW'(r_m1_px) << 15) - AW'(r_m1_px);
    assign w_my = (AW'(r_m1_py) << 15) - AW'(r_m1_py);
    assign w_rh = AW'(r_m1_r) << F;
    assign w_nx = (w_mx << 1) + w_rh;
    assign w_ny = (w_my << 1) + w_rh;

    logic        r_m2_vld;
    logic [31:0] r_m2_bx, r_m2_by;
    logic        r_m2_sx, r_m2_sy, r_m2_live;
    logic [15:0] r_m2_r, r_m2_tq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_bx   <= w_nx[F+32:F+1];
            r_m2_by   <= w_ny[F+32:F+1];
            r_m2_sx   <= r_m1_sx;
            r_m2_sy   <= r_m1_sy;
            r_m2_live <= r_m1_live;
            r_m2_r    <= r_m1_live ? r_m1_r : 16'd1;
            r_m2_tq   <= r_m1_tq;
        end
    end

    // axis dividers, divide by the magnitude
    logic        w_dx_vld, w_dy_vld;
    logic [15:0] w_qx, w_qy;
    logic        w_dx_sx;
    logic [17:0] w_dy_pay;

    rdz_div_pipe #(.QW(16), .DW(16), .PW(1)) u_x_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m2_vld),
        .i_num   (r_m2_bx),
        .i_den   (r_m2_r),
        .i_pay   (r_m2_sx),
        .o_vld   (w_dx_vld),
        .o_quo   (w_qx),
        .o_pay   (w_dx_sx)
    );

    rdz_div_pipe #(.QW(16), .DW(16), .PW(18)) u_y_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m2_vld),
        .i_num   (r_m2_by),
        .i_den   (r_m2_r),
        .i_pay   ({r_m2_sy, r_m2_live, r_m2_tq}),
        .o_vld   (w_dy_vld),
        .o_quo   (w_qy),
        .o_pay   (w_dy_pay)
    );

    // output register
    logic [15:0] w_satx, w_saty, w_ox, w_oy;
    logic        w_o_live;

    assign w_o_live = w_dy_pay[16];
    assign w_satx   = (w_qx > {1'b0, STICK_FULL}) ? {1'b0, STICK_FULL} : w_qx;
    assign w_saty   = (w_qy > {1'b0, STICK_FULL}) ? {1'b0, STICK_FULL} : w_qy;
    assign w_ox     = !w_o_live ? '0 : (w_dx_sx ? 16'(-w_satx) : w_satx);
    assign w_oy     = !w_o_live ? '0 : (w_dy_pay[17] ? 16'(-w_saty) : w_saty);

    logic        r_o_vld;
    logic [47:0] r_o_data;

    assign w_en       = !r_o_vld || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= w_dx_vld & w_dy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= {w_dy_pay[15:0], w_oy, w_ox};
        end
    end

endmodule

`default_nettype wire
